### design/gmt_pkg.sv
// Shared types and constants for the Web Mercator tile position pipeline.
package gmt_pkg;

  localparam int unsigned MAX_ZOOM_DEF  = 21;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned ZW  = 5;
  localparam int unsigned TXW = 38;

  localparam logic [ZW-1:0] ZOOM_RST = 5'd17;

  localparam logic signed [30:0] LAT_LIMIT = 31'sd754974720;
  localparam logic signed [31:0] LON_LIMIT = 32'sd1509949440;

  localparam logic [31:0] DEG2RAD_Q37 = 32'd2398762259;
  localparam logic [27:0] K_Q32       = 28'd236905672;
  localparam logic [30:0] ONE_Q30     = 31'd1 << 30;
  localparam logic [62:0] HALF_Q62    = 63'd1 << 61;

  // Taylor series divisors for the Horner evaluation of the sine, innermost first.
  localparam int unsigned HORNER_DIV [8] = '{272, 210, 156, 110, 72, 42, 20, 6};

  typedef struct packed {
    logic           north;
    logic [ZW-1:0]  z;
    logic [TXW-1:0] tx;
    logic           x_ok;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] phi;
    logic [31:0] x2;
    logic [30:0] t;
  } hor_t;

  typedef struct packed {
    side_t       side;
    logic        pole;
    logic [30:0] mp;
    logic [30:0] mm;
    logic [29:0] fp;
    logic [29:0] fm;
    logic [4:0]  nm;
  } log_t;

endpackage

### design/gmt_horner_cell.sv
// One Horner step of the sine series: t = 1 - (x2 * t) / DIV, over two stages.
module gmt_horner_cell #(
  parameter int unsigned DIV = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  gmt_pkg::hor_t pay_i,
  output logic          vld_o,
  output gmt_pkg::hor_t pay_o
);
  import gmt_pkg::*;

  // Division by the constant is a multiplication by a rounded-up reciprocal; the error
  // stays below 1/DIV for any 32-bit dividend, so the floor is exact.
  localparam int unsigned SHR = 32 + $clog2(DIV);
  localparam logic [32:0] MAG = 33'(((64'd1 << SHR) + 64'(DIV) - 64'd1) / 64'(DIV));

  logic        vld1_q;
  hor_t        pay1_q;
  logic [31:0] w1_q;
  logic [63:0] prod1;
  logic [64:0] prod2;
  logic [29:0] quo;
  logic        vld2_q;
  hor_t        pay2_q;
  hor_t        pay2_d;

  assign prod1 = 64'(pay_i.x2) * 64'(pay_i.t);
  assign prod2 = {33'b0, w1_q} * {32'b0, MAG};
  assign quo   = 30'(prod2 >> SHR);

  always_comb begin
    pay2_d   = pay1_q;
    pay2_d.t = ONE_Q30 - 31'(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay1_q <= pay_i;
      w1_q   <= prod1[61:30];
      pay2_q <= pay2_d;
    end
  end

  assign vld_o = vld2_q;
  assign pay_o = pay2_q;

endmodule

### design/gmt_log_cell.sv
// One squaring step of the bit-by-bit log2 for both the plus and the minus mantissa.
module gmt_log_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  gmt_pkg::log_t pay_i,
  output logic          vld_o,
  output gmt_pkg::log_t pay_o
);
  import gmt_pkg::*;

  logic        vld_q;
  log_t        pay_q;
  log_t        pay_d;
  logic [61:0] sqp;
  logic [61:0] sqm;

  assign sqp = 62'(pay_i.mp) * 62'(pay_i.mp);
  assign sqm = 62'(pay_i.mm) * 62'(pay_i.mm);

  // A squared mantissa at or above two yields a one bit of the result and is halved.
  always_comb begin
    pay_d    = pay_i;
    pay_d.mp = sqp[61] ? sqp[61:31] : sqp[60:30];
    pay_d.fp = {pay_i.fp[28:0], sqp[61]};
    pay_d.mm = sqm[61] ? sqm[61:31] : sqm[60:30];
    pay_d.fm = {pay_i.fm[28:0], sqm[61]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= pay_d;
    end
  end

  assign vld_o = vld_q;
  assign pay_o = pay_q;

endmodule

### design/geo_to_mercator_tile_position.sv
// Top level: latitude and longitude to Web Mercator tile position, fully pipelined.
//
//  Channel  Direction  Handshake                     Contents
//  s_axis   in         s_axis_tvalid/s_axis_tready   lat_deg, lon_deg
//  m_axis   out        m_axis_tvalid/m_axis_tready   tile_x, tile_y, in_grid
//  cfg      in         cfg_valid_i/cfg_ready_o       zoom_level
//
// One transfer in per cycle when the output is not stalled; a result passes through
// 57 register stages on its way to the output. The depth is set by the cell chains:
// eight two-stage Horner cells for the sine and thirty squaring cells for the
// logarithms. Reset clears all valid flags and sets the zoom to 17; cfg is always ready.
// A stalled output fills a one-entry skid register, after which s_axis_tready drops and
// the whole pipeline holds.
module geo_to_mercator_tile_position #(
  parameter int unsigned MAX_ZOOM  = gmt_pkg::MAX_ZOOM_DEF,
  parameter int unsigned FRAC_BITS = gmt_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [30:0] lat_deg, [62:31] lon_deg, [63] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [37:0] tile_x, [75:38] tile_y, [79:76] zero
  output logic        m_axis_tuser,   // [0] in_grid
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i      // [4:0] zoom_level
);
  import gmt_pkg::*;

  localparam int unsigned SHMAX = MAX_ZOOM + FRAC_BITS;
  localparam int unsigned CW    = SHMAX + 28;
  localparam logic [32:0] M45   = 33'(((64'd1 << 38) + 64'd44) / 64'd45);
  localparam logic [ZW-1:0] ZMAX = ZW'(MAX_ZOOM);

  logic [ZW-1:0] zoom_q;
  logic          en;

  // Front end
  logic signed [30:0] lat_in, lat_c;
  logic signed [31:0] lon_in, lon_c;
  side_t              side_d;

  logic        f1_vld_q;
  side_t       f1_side_q;
  logic [31:0] f1_u_q;
  logic [29:0] f1_alat_q;

  logic        f2_vld_q;
  side_t       f2_side_q;
  logic [31:0] f2_u_q;
  logic [64:0] f2_pa_q;
  logic [62:0] f2_pp_q;

  logic [26:0] a_d;
  logic [31:0] rem_d;
  logic        f3_vld_q;
  side_t       f3_side_q;
  logic [26:0] f3_a_q;
  logic [5:0]  f3_b_q;
  logic [30:0] f3_phi_q;

  logic [SHMAX-1:0] frac_tab [45];
  logic [5:0]       f3_sh;
  logic [CW-1:0]    cmb;
  logic [CW-1:0]    tx_full;
  side_t       f4_side_d;
  logic        f4_vld_q;
  side_t       f4_side_q;
  logic [30:0] f4_phi_q;
  logic [61:0] f4_x2p_q;

  // Chains
  logic hor_vld [9];
  hor_t hor_pay [9];
  logic log_vld [31];
  log_t log_pay [31];

  // Sine product, logarithm input
  logic        s1_vld_q;
  side_t       s1_side_q;
  logic [61:0] s1_sp_q;
  logic        s2_vld_q;
  side_t       s2_side_q;
  logic        s2_pole_q;
  logic [29:0] s2_s_q;
  logic [30:0] minus;
  logic [4:0]  nmsb;
  log_t        log_d;
  logic        log0_vld_q;
  log_t        log0_pay_q;

  // Back end
  logic        e1_vld_q;
  side_t       e1_side_q;
  logic        e1_pole_q;
  logic [34:0] e1_d_q;
  logic        e2_vld_q;
  side_t       e2_side_q;
  logic        e2_pole_q;
  logic [62:0] e2_p_q;
  logic [62:0] pc;
  logic [62:0] fy;
  logic [5:0]  e2_sh;
  logic        e3_vld_q;
  logic [TXW-1:0] e3_tx_q;
  logic [TXW-1:0] e3_ty_q;
  logic        e3_grid_q;

  logic           out_v_q;
  logic           skid_v_q;
  logic [TXW-1:0] out_tx_q, out_ty_q, skid_tx_q, skid_ty_q;
  logic           out_g_q, skid_g_q;

  assign cfg_ready_o   = 1'b1;
  assign en            = !skid_v_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q <= ZOOM_RST;
    end else if (cfg_valid_i) begin
      zoom_q <= cfg_data_i;
    end
  end

  // Stage 1: clamp, offset the longitude, fold the latitude.
  always_comb begin
    lat_in = signed'(s_axis_tdata[30:0]);
    lon_in = signed'(s_axis_tdata[62:31]);
    if (lat_in > LAT_LIMIT) begin
      lat_c = LAT_LIMIT;
    end else if (lat_in < -LAT_LIMIT) begin
      lat_c = -LAT_LIMIT;
    end else begin
      lat_c = lat_in;
    end
    if (lon_in > LON_LIMIT) begin
      lon_c = LON_LIMIT;
    end else if (lon_in < -LON_LIMIT) begin
      lon_c = -LON_LIMIT;
    end else begin
      lon_c = lon_in;
    end
    side_d       = '0;
    side_d.north = lat_c > 31'sd0;
    side_d.z     = (zoom_q > ZMAX) ? ZMAX : zoom_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q   <= 1'b0;
      f2_vld_q   <= 1'b0;
      f3_vld_q   <= 1'b0;
      f4_vld_q   <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      e1_vld_q   <= 1'b0;
      e2_vld_q   <= 1'b0;
      e3_vld_q   <= 1'b0;
      log0_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q   <= s_axis_tvalid;
      f2_vld_q   <= f1_vld_q;
      f3_vld_q   <= f2_vld_q;
      f4_vld_q   <= f3_vld_q;
      s1_vld_q   <= hor_vld[8];
      s2_vld_q   <= s1_vld_q;
      log0_vld_q <= s2_vld_q;
      e1_vld_q   <= log_vld[30];
      e2_vld_q   <= e1_vld_q;
      e3_vld_q   <= e2_vld_q;
    end
  end

  // Stage 3 splits u into u = 45 * a + b; stage 4 then forms floor(u * 2^sh / (45 * 2^26)).
  assign a_d   = f2_pa_q[64:38];
  assign rem_d = f2_u_q - 32'(32'(a_d) * 32'd45);

  for (genvar gi = 0; gi < 45; gi++) begin : g_tab
    assign frac_tab[gi] = SHMAX'((64'(gi) << SHMAX) / 64'd45);
  end

  assign f3_sh   = 6'(f3_side_q.z) + 6'(FRAC_BITS);
  assign cmb     = (CW'(f3_a_q) << f3_sh) + CW'(frac_tab[f3_b_q] >> (SHMAX - f3_sh));
  assign tx_full = cmb >> 26;

  always_comb begin
    f4_side_d      = f3_side_q;
    f4_side_d.tx   = TXW'(tx_full);
    f4_side_d.x_ok = (tx_full >> f3_sh) == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_side_q <= side_d;
      f1_u_q    <= unsigned'(lon_c) + unsigned'(LON_LIMIT);
      f1_alat_q <= 30'((lat_c < 31'sd0) ? -lat_c : lat_c);

      f2_side_q <= f1_side_q;
      f2_u_q    <= f1_u_q;
      f2_pa_q   <= {33'b0, f1_u_q} * {32'b0, M45};
      f2_pp_q   <= 63'(f1_alat_q) * 63'(DEG2RAD_Q37);

      f3_side_q <= f2_side_q;
      f3_a_q    <= a_d;
      f3_b_q    <= rem_d[5:0];
      f3_phi_q  <= 31'((f2_pp_q + (63'd1 << 29)) >> 30);

      f4_side_q <= f4_side_d;
      f4_phi_q  <= f3_phi_q;
      f4_x2p_q  <= 62'(f3_phi_q) * 62'(f3_phi_q);
    end
  end

  assign hor_vld[0]      = f4_vld_q;
  assign hor_pay[0].side = f4_side_q;
  assign hor_pay[0].phi  = f4_phi_q;
  assign hor_pay[0].x2   = f4_x2p_q[61:30];
  assign hor_pay[0].t    = ONE_Q30;

  for (genvar k = 0; k < 8; k++) begin : g_hor
    gmt_horner_cell #(
      .DIV (HORNER_DIV[k])
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (hor_vld[k]),
      .pay_i  (hor_pay[k]),
      .vld_o  (hor_vld[k+1]),
      .pay_o  (hor_pay[k+1])
    );
  end

  // The logarithm of 1 + s always has exponent 30; the minus lane is normalised here.
  always_comb begin
    minus = ONE_Q30 - 31'(s2_s_q);
    nmsb  = '0;
    for (int i = 0; i < 31; i++) begin
      if (minus[i]) begin
        nmsb = 5'(i);
      end
    end
    log_d      = '0;
    log_d.side = s2_side_q;
    log_d.pole = s2_pole_q;
    log_d.mp   = {1'b1, s2_s_q};
    log_d.mm   = minus << (5'd30 - nmsb);
    log_d.nm   = nmsb;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q  <= hor_pay[8].side;
      s1_sp_q    <= 62'(hor_pay[8].phi) * 62'(hor_pay[8].t);
      s2_side_q  <= s1_side_q;
      s2_pole_q  <= s1_sp_q[61:30] >= 32'(ONE_Q30);
      s2_s_q     <= s1_sp_q[59:30];
      log0_pay_q <= log_d;
    end
  end

  assign log_vld[0] = log0_vld_q;
  assign log_pay[0] = log0_pay_q;

  for (genvar k = 0; k < 30; k++) begin : g_log
    gmt_log_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (log_vld[k]),
      .pay_i  (log_pay[k]),
      .vld_o  (log_vld[k+1]),
      .pay_o  (log_pay[k+1])
    );
  end

  // The projected distance from the equator is clamped at half the grid, then mirrored.
  assign e2_sh = 6'(e2_side_q.z) + 6'(FRAC_BITS);
  assign pc    = (e2_pole_q || (e2_p_q > HALF_Q62)) ? HALF_Q62 : e2_p_q;
  assign fy    = e2_side_q.north ? (HALF_Q62 - pc) : (HALF_Q62 + pc);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_side_q <= log_pay[30].side;
      e1_pole_q <= log_pay[30].pole;
      e1_d_q    <= {5'd30, log_pay[30].fp} - {log_pay[30].nm, log_pay[30].fm};
      e2_side_q <= e1_side_q;
      e2_pole_q <= e1_pole_q;
      e2_p_q    <= 63'(e1_d_q) * 63'(K_Q32);
      e3_tx_q   <= e2_side_q.tx;
      e3_ty_q   <= TXW'(fy >> (6'd62 - e2_sh));
      e3_grid_q <= e2_side_q.x_ok && !fy[62];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= e3_vld_q;
      end
    end else if (e3_vld_q && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      if (skid_v_q) begin
        out_tx_q <= skid_tx_q;
        out_ty_q <= skid_ty_q;
        out_g_q  <= skid_g_q;
      end else begin
        out_tx_q <= e3_tx_q;
        out_ty_q <= e3_ty_q;
        out_g_q  <= e3_grid_q;
      end
    end else if (en) begin
      skid_tx_q <= e3_tx_q;
      skid_ty_q <= e3_ty_q;
      skid_g_q  <= e3_grid_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0, out_ty_q, out_tx_q};
  assign m_axis_tuser  = out_g_q;

endmodule

### design/gmt_checker.sv
// Port-level checks on the tile position block, bound to its top level.
module gmt_checker #(
  parameter int unsigned MAX_ZOOM  = gmt_pkg::MAX_ZOOM_DEF,
  parameter int unsigned FRAC_BITS = gmt_pkg::FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  localparam int unsigned SH = MAX_ZOOM + FRAC_BITS;

  logic [63:0] tx, ty;

  assign tx = 64'(m_axis_tdata[37:0]);
  assign ty = 64'(m_axis_tdata[75:38]);

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output changed while stalled");

  // The input side only stalls once a result is waiting.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  // Positions never exceed the full grid at the largest zoom.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (tx <= (64'd1 << SH)) && (ty <= (64'd1 << SH)))
    else $error("tile position beyond grid");

  // A tile inside the grid has integer parts below the largest tile count.
  a_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> ((tx >> SH) == 64'd0) && ((ty >> SH) == 64'd0))
    else $error("in_grid set for a tile outside the grid");

endmodule

bind geo_to_mercator_tile_position gmt_checker #(
  .MAX_ZOOM  (MAX_ZOOM),
  .FRAC_BITS (FRAC_BITS)
) u_gmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_geo_to_mercator_tile_position.sv
// Self-checking testbench for the Web Mercator tile position pipeline.
`timescale 1ns / 1ps

module tb_geo_to_mercator_tile_position;
  import gmt_pkg::*;

  localparam int unsigned LATENCY   = 57;
  localparam longint      CYCLE_CAP = 400000;

  typedef struct {
    logic [37:0] tx;
    logic [37:0] ty;
    logic        grid;
  } tile_t;

  typedef struct {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic               known;
    tile_t              want;
  } row_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i, cfg_ready_o;
  logic [4:0]  cfg_data_i;

  geo_to_mercator_tile_position dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  logic [4:0] zoom_reg;
  tile_t      pending_tiles[$];
  int         errors, mismatches, sent, received;
  int         src_idle_pct, sink_stall_pct;
  bit         hold_sink;
  longint     cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [63:0] log2_fix(logic [63:0] v);
    int          n;
    logic [63:0] m, r;
    n = 0;
    while (n < 63 && (v >> (n + 1)) != 0) n++;
    m = (n <= 30) ? (v << (30 - n)) : (v >> (n - 30));
    r = 64'(n) << 30;
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r |= 64'd1 << (30 - i);
      end
    end
    return r;
  endfunction

  function automatic tile_t project(logic signed [30:0] lat_in, logic signed [31:0] lon_in,
                                    logic [4:0] zoom);
    int unsigned  z, sh;
    longint       lat, lon;
    logic [63:0]  u, tx, ty, alat, phi, x2, t, s, d, p, f;
    bit           north;
    tile_t        res;
    z = (zoom > MAX_ZOOM_DEF) ? MAX_ZOOM_DEF : zoom;
    sh = z + FRAC_BITS_DEF;
    lat = lat_in;
    lon = lon_in;
    if (lon > longint'(LON_LIMIT)) lon = LON_LIMIT;
    if (lon < -longint'(LON_LIMIT)) lon = -longint'(LON_LIMIT);
    if (lat > longint'(LAT_LIMIT)) lat = LAT_LIMIT;
    if (lat < -longint'(LAT_LIMIT)) lat = -longint'(LAT_LIMIT);
    u = 64'(lon + longint'(LON_LIMIT));
    tx = (sh >= 26) ? (u << (sh - 26)) / 45 : u / (64'd45 << (26 - sh));
    north = lat > 0;
    alat = 64'((lat < 0) ? -lat : lat);
    phi = (alat * 64'(DEG2RAD_Q37) + (64'd1 << 29)) >> 30;
    x2 = (phi * phi) >> 30;
    t = 64'd1 << 30;
    for (int k = 0; k < 8; k++)
      t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'(HORNER_DIV[k]);
    s = (phi * t) >> 30;
    if (s > (64'd1 << 30)) s = 64'd1 << 30;
    if (s >= (64'd1 << 30)) begin
      p = 64'd1 << 61;
    end else begin
      d = log2_fix((64'd1 << 30) + s) - log2_fix((64'd1 << 30) - s);
      p = d * 64'(K_Q32);
      if (p > (64'd1 << 61)) p = 64'd1 << 61;
    end
    f = north ? (64'd1 << 61) - p : (64'd1 << 61) + p;
    if (f > (64'd1 << 62)) f = 64'd1 << 62;
    ty = f >> (62 - sh);
    res.tx = tx[37:0];
    res.ty = ty[37:0];
    res.grid = ((tx >> FRAC_BITS_DEF) < (64'd1 << z)) && ((ty >> FRAC_BITS_DEF) < (64'd1 << z));
    return res;
  endfunction

  // The valid line only drops while the sender idles, so each step sees one update.
  task automatic send_point(logic signed [30:0] lat, logic signed [31:0] lon);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, lon, lat};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_tiles.insert(pending_tiles.size(), project(lat, lon, zoom_reg));
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_tiles.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic write_zoom(logic [4:0] zoom);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= zoom;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    zoom_reg = zoom;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [30:0] rand_lat();
    case ($urandom_range(9))
      0: return 31'($urandom);
      1: return $urandom_range(1) ? LAT_LIMIT - 31'($urandom_range(100000))
                                  : -LAT_LIMIT + 31'($urandom_range(100000));
      default: return 31'(longint'($urandom_range(2 * 713031680)) - 713031680);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_lon();
    if ($urandom_range(9) == 0) return 32'($urandom);
    return 32'(longint'($urandom_range(32'd3019898880)) - longint'(LON_LIMIT));
  endfunction

  // Sink: random stalls, plus a long hold-off requested by the stimulus.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    tile_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      received++;
      if (pending_tiles.size() == 0) begin
        errors++;
        $display("Unexpected result transfer: data %h", m_axis_tdata);
      end else begin
        want = pending_tiles.pop_front();
        if (m_axis_tdata[37:0] !== want.tx || m_axis_tdata[75:38] !== want.ty ||
            m_axis_tuser !== want.grid) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: x %h/%h y %h/%h grid %b/%b (expected/actual)",
                     want.tx, m_axis_tdata[37:0], want.ty, m_axis_tdata[75:38],
                     want.grid, m_axis_tuser);
        end
      end
    end
  end

  row_t       rows[$];
  logic [4:0] zoom_plan[6] = '{5'd0, 5'd21, 5'd31, 5'd1, 5'd8, 5'd22};

  initial begin
    tile_t got;
    errors = 0; mismatches = 0; sent = 0; received = 0;
    src_idle_pct = 0; sink_stall_pct = 0; hold_sink = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_valid_i = 1'b0; cfg_data_i = '0;
    zoom_reg = ZOOM_RST;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table at the reset zoom of 17; equator, poles and the wrap edge are typed in.
    rows.insert(rows.size(), row_t'{31'sd0, 32'sd0, 1'b1, '{38'h1 << 32, 38'h1 << 32, 1'b1}});
    rows.insert(rows.size(), row_t'{31'sd0, -LON_LIMIT, 1'b1, '{38'h0, 38'h1 << 32, 1'b1}});
    rows.insert(rows.size(), row_t'{31'sd0, LON_LIMIT, 1'b1, '{38'h1 << 33, 38'h1 << 32, 1'b0}});
    rows.insert(rows.size(), row_t'{LAT_LIMIT, 32'sd0, 1'b1, '{38'h1 << 32, 38'h0, 1'b1}});
    rows.insert(rows.size(), row_t'{-LAT_LIMIT, 32'sd0, 1'b1, '{38'h1 << 32, 38'h1 << 33, 1'b0}});
    rows.insert(rows.size(), row_t'{31'h3fffffff, 32'h7fffffff, 1'b1,
                                    '{38'h1 << 33, 38'h0, 1'b0}});
    rows.insert(rows.size(), row_t'{31'h40000000, 32'h80000000, 1'b1,
                                    '{38'h0, 38'h1 << 33, 1'b0}});
    rows.insert(rows.size(), row_t'{31'sd1, 32'sd1, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{-31'sd1, -32'sd1, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{31'sd713031680, 32'sd100, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{-31'sd713031680, -32'sd100, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{31'sd720000000, 32'sd5, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{31'sd754000000, 32'sd1509949439, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{-31'sd754000000, -32'sd1509949439, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{31'sd431000000, -32'sd620000000, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{31'h2aaaaaaa, 32'h55555555, 1'b0, '{0, 0, 0}});
    rows.insert(rows.size(), row_t'{31'h55555555, 32'haaaaaaaa, 1'b0, '{0, 0, 0}});
    foreach (rows[i]) begin
      if (rows[i].known) begin
        got = project(rows[i].lat, rows[i].lon, zoom_reg);
        if (got != rows[i].want) begin
          errors++;
          $display("Predictor disagrees with directed row %0d", i);
        end
      end
      send_point(rows[i].lat, rows[i].lon);
    end
    drain_results();

    // Each phase changes the zoom while idle, then streams random points.
    for (int ph = 0; ph < 6; ph++) begin
      write_zoom(zoom_plan[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default: begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      for (int n = 0; n < 255; n++) begin
        if (ph == 0 && n == 40) begin
          hold_sink = 1'b1;
          fork
            begin
              repeat (150) @(negedge clk_i);
              hold_sink = 1'b0;
            end
          join_none
        end
        if (n == 128) drain_results();
        send_point(rand_lat(), rand_lon());
      end
      drain_results();
    end

    $display("Sent %0d points, checked %0d tiles over six zoom settings incl. 0, 21 and 31.",
             sent, received);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
